@@ src/rac_pkg.sv @@
package rac_pkg;

  localparam int FRAC_BITS = 16;
  localparam int S2F       = 2 * FRAC_BITS;

  localparam int SENW  = 6;
  localparam int XW    = 32;   // inputs, Q format
  localparam int RW    = 33;   // residuals
  localparam int PW    = 65;   // 33 x 32 products
  localparam int DW    = 64;   // denominator
  localparam int DOTW  = 66;   // dot and cross terms
  localparam int LOW   = 33;   // low slice of dot for the split multiply
  localparam int NW    = 97;   // numerators
  localparam int MW    = 97;   // dividend and remainder
  localparam int QW    = 31;   // quotient bits below saturation
  localparam int LANES = 3;

  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_G = 2;

  localparam int NFIX  = 5;          // front stages before the divider
  localparam int NDIV  = QW + 2;     // prep, saturation check, one stage per bit
  localparam int NS    = NFIX + NDIV + 1;

  typedef struct packed {
    logic [LANES-1:0][MW-1:0] m;
    logic [LANES-1:0][QW-1:0] q;
    logic [LANES-1:0]         neg;
    logic [LANES-1:0]         sat;
    logic [DW-1:0]            den;
    logic [SENW-1:0]          sensor;
  } div_t;

endpackage

@@ src/rac_in_if.sv @@
interface rac_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  sensor_index;
  logic        in_track;
  logic [31:0] track_u;
  logic [31:0] track_v;
  logic [31:0] meas_u;
  logic [31:0] meas_v;

  modport source (output valid, sensor_index, in_track, track_u, track_v, meas_u, meas_v,
                  input ready);
  modport sink   (input valid, sensor_index, in_track, track_u, track_v, meas_u, meas_v,
                  output ready);
endinterface

@@ src/rac_out_if.sv @@
interface rac_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  sensor_out;
  logic [31:0] corr_u;
  logic [31:0] corr_v;
  logic [31:0] corr_gamma;

  modport source (output valid, sensor_out, corr_u, corr_v, corr_gamma, input ready);
  modport sink   (input valid, sensor_out, corr_u, corr_v, corr_gamma, output ready);
endinterface

@@ src/residual_alignment_correction_unit.sv @@
// one request per cycle sustained while the output is ready
// five arithmetic stages, then a restoring divider of one quotient bit per stage for
// each of the three corrections, then the output register
// each stage moves when empty or when the next one moves, so bubbles close up
// reset (rst_ni low, asynchronous) empties every stage; requests off track give no result
module residual_alignment_correction_unit import rac_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rac_in_if.sink     in_i,
  rac_out_if.source  out_o
);

  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_i.valid && in_i.in_track;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: residuals
  logic [SENW-1:0]        sen0_q;
  logic signed [XW-1:0]   u0_q, v0_q;
  logic signed [RW-1:0]   ru0_q, rv0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      sen0_q <= in_i.sensor_index;
      u0_q   <= $signed(in_i.track_u);
      v0_q   <= $signed(in_i.track_v);
      ru0_q  <= RW'($signed(in_i.meas_u)) - RW'($signed(in_i.track_u));
      rv0_q  <= RW'($signed(in_i.meas_v)) - RW'($signed(in_i.track_v));
    end
  end

  // stage 1: products
  logic [SENW-1:0]        sen1_q;
  logic signed [XW-1:0]   u1_q, v1_q;
  logic signed [RW-1:0]   ru1_q, rv1_q;
  logic signed [DW-1:0]   uu1_q, vv1_q;
  logic signed [PW-1:0]   ruu1_q, rvv1_q, ruv1_q, rvu1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      sen1_q <= sen0_q;
      u1_q   <= u0_q;
      v1_q   <= v0_q;
      ru1_q  <= ru0_q;
      rv1_q  <= rv0_q;
      uu1_q  <= u0_q * u0_q;
      vv1_q  <= v0_q * v0_q;
      ruu1_q <= ru0_q * u0_q;
      rvv1_q <= rv0_q * v0_q;
      ruv1_q <= ru0_q * v0_q;
      rvu1_q <= rv0_q * u0_q;
    end
  end

  // stage 2: denominator, dot and cross terms
  logic [SENW-1:0]        sen2_q;
  logic signed [XW-1:0]   u2_q, v2_q;
  logic signed [RW-1:0]   ru2_q, rv2_q;
  logic [DW-1:0]          den2_q;
  logic signed [DOTW-1:0] dot2_q, cr2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      sen2_q <= sen1_q;
      u2_q   <= u1_q;
      v2_q   <= v1_q;
      ru2_q  <= ru1_q;
      rv2_q  <= rv1_q;
      den2_q <= (DW'(1) << S2F) + DW'(uu1_q) + DW'(vv1_q);
      dot2_q <= DOTW'(ruu1_q) + DOTW'(rvv1_q);
      cr2_q  <= DOTW'(ruv1_q) - DOTW'(rvu1_q);
    end
  end

  // stage 3: position times dot, split in two partial products
  logic [SENW-1:0]          sen3_q;
  logic signed [RW-1:0]     ru3_q, rv3_q;
  logic [DW-1:0]            den3_q;
  logic signed [DOTW-1:0]   cr3_q;
  logic signed [DOTW-1:0]   plu3_q, plv3_q;
  logic signed [PW-1:0]     phu3_q, phv3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      sen3_q <= sen2_q;
      ru3_q  <= ru2_q;
      rv3_q  <= rv2_q;
      den3_q <= den2_q;
      cr3_q  <= cr2_q;
      plu3_q <= u2_q * $signed({1'b0, dot2_q[LOW-1:0]});
      plv3_q <= v2_q * $signed({1'b0, dot2_q[LOW-1:0]});
      phu3_q <= u2_q * $signed(dot2_q[DOTW-1:LOW]);
      phv3_q <= v2_q * $signed(dot2_q[DOTW-1:LOW]);
    end
  end

  // stage 4: numerators before the sign flip of du and dv
  logic [SENW-1:0]        sen4_q;
  logic [DW-1:0]          den4_q;
  logic signed [NW-1:0]   xu4_q, xv4_q, xg4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      sen4_q <= sen3_q;
      den4_q <= den3_q;
      xu4_q  <= (NW'(ru3_q) <<< S2F) + (NW'(phu3_q) <<< LOW) + NW'(plu3_q);
      xv4_q  <= (NW'(rv3_q) <<< S2F) + (NW'(phv3_q) <<< LOW) + NW'(plv3_q);
      xg4_q  <= NW'(cr3_q) <<< FRAC_BITS;
    end
  end

  // divider stages
  div_t d_q [NDIV];
  div_t dn  [NDIV];

  always_comb begin
    logic [LANES-1:0][NW-1:0] x;
    logic [MW-1:0]            ab;
    logic [MW-1:0]            dsh;
    logic [MW:0]              diff;
    x[LANE_U] = xu4_q;
    x[LANE_V] = xv4_q;
    x[LANE_G] = xg4_q;
    dn[0] = '0;
    dn[0].den    = den4_q;
    dn[0].sensor = sen4_q;
    for (int l = 0; l < LANES; l++) begin
      ab = x[l][NW-1] ? MW'(-x[l]) : MW'(x[l]);
      dn[0].m[l] = ab + MW'(den4_q >> 1);
      // du and dv carry a leading minus
      dn[0].neg[l] = (l == LANE_G) ? x[l][NW-1] : !x[l][NW-1];
    end
    dn[1] = d_q[0];
    dsh = MW'(d_q[0].den) << QW;
    for (int l = 0; l < LANES; l++) begin
      dn[1].sat[l] = d_q[0].m[l] >= dsh;
    end
    for (int j = 0; j < QW; j++) begin
      dn[j+2] = d_q[j+1];
      dsh = MW'(d_q[j+1].den) << (QW - 1 - j);
      for (int l = 0; l < LANES; l++) begin
        diff = {1'b0, d_q[j+1].m[l]} - {1'b0, dsh};
        if (!diff[MW]) begin
          dn[j+2].m[l]            = diff[MW-1:0];
          dn[j+2].q[l][QW-1-j]    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NDIV; i++) begin
      if (rdy[NFIX+i]) d_q[i] <= dn[i];
    end
  end

  // output stage: sign and saturation
  logic [LANES-1:0][XW-1:0] res;
  logic [LANES-1:0][XW-1:0] res_q;
  logic [SENW-1:0]          sen_out_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (d_q[NDIV-1].sat[l]) begin
        res[l] = d_q[NDIV-1].neg[l] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
      end else if (d_q[NDIV-1].neg[l]) begin
        res[l] = XW'(0) - {1'b0, d_q[NDIV-1].q[l]};
      end else begin
        res[l] = {1'b0, d_q[NDIV-1].q[l]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      res_q     <= res;
      sen_out_q <= d_q[NDIV-1].sensor;
    end
  end

  assign out_o.valid      = v_q[NS-1];
  assign out_o.sensor_out = sen_out_q;
  assign out_o.corr_u     = res_q[LANE_U];
  assign out_o.corr_v     = res_q[LANE_V];
  assign out_o.corr_gamma = res_q[LANE_G];

  a_drop_off_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.in_track) |=> !v_q[0])
    else $error("off-track request entered the pipeline");

  a_no_refuse_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_i.ready)
    else $error("input refused while first stage is empty");

  // a saturated dividend exceeds every shifted divisor, so all quotient bits set
  a_sat_quotient_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-2] && d_q[NDIV-1].sat[LANE_U]) |-> (d_q[NDIV-1].q[LANE_U] == '1))
    else $error("saturated lane left quotient bits clear");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NS-1] && !out_o.ready) |=> (v_q[NS-1] && $stable(res_q)))
    else $error("stalled result changed");

endmodule
